// File: rtl/core/soq_pkg.sv
// ----------------------------------------------------------------------------
// soq_pkg
// shared constants and types of the spooling output queue
// ----------------------------------------------------------------------------
`default_nettype none
package soq_pkg;
  localparam int WellDepth = 64;
  localparam int NumDesc   = 8;
  localparam int NumProd   = 2;
  localparam int WAW = $clog2(WellDepth);
  localparam int WCW = $clog2(WellDepth + 1);
  localparam int DAW = (NumDesc > 1) ? $clog2(NumDesc) : 1;
  localparam int DCW = $clog2(NumDesc + 1);
  localparam int MAW = $clog2(NumProd * WellDepth);
  localparam int DESCW = 1 + WAW + WCW;

  localparam logic [1:0] P_READY = 2'd0;
  localparam logic [1:0] P_WAIT_SPACE = 2'd1;
  localparam logic [1:0] P_WAIT_DESC = 2'd2;
  localparam logic [1:0] P_EXITED = 2'd3;
  localparam logic [1:0] S_READY = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_EXITED = 2'd2;

  localparam logic [2:0] OC_OK = 3'd0;
  localparam logic [2:0] OC_NOT_READY = 3'd1;
  localparam logic [2:0] OC_FULL = 3'd2;
  localparam logic [2:0] OC_NO_DESC = 3'd3;
  localparam logic [2:0] OC_SPOOL_WAIT = 3'd4;
  localparam logic [2:0] OC_SPOOL_EXIT = 3'd5;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_SPOOL = 1'b1;

  localparam logic [1:0] REG_FILES0 = 2'd0;
  localparam logic [1:0] REG_FILES1 = 2'd1;

  typedef struct packed {
    logic       has_word;
    logic       owner;
    logic [7:0] out_word;
    logic       last;
    logic [2:0] outcome;
    logic [1:0] state_producer0;
    logic [1:0] state_producer1;
    logic [1:0] state_spooler;
    logic [3:0] free_descriptors;
  } res_t;

  typedef struct packed {
    logic       action;
    logic       producer;
    logic [7:0] word;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic exec;      // run the item's state update, prepare first beat
    logic rd_next;   // issue the next well read of a drain
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drain;     // the item drains words
    logic [WCW-1:0] len;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/core/soq_if.sv
// ----------------------------------------------------------------------------
// soq_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface soq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/soq_ram.sv
// ----------------------------------------------------------------------------
// soq_ram
// simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module soq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/soq_datapath.sv
// ----------------------------------------------------------------------------
// soq_datapath
// wells, descriptor ring, producer and spooler state, result forming
// ----------------------------------------------------------------------------
`default_nettype none
module soq_datapath import soq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire item_t      item_i,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  output res_t            res_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  output logic [7:0]      files0_o,
  output logic [7:0]      files1_o
);
  logic [7:0] files_q [NumProd];
  logic [7:0] left_q [NumProd];
  logic [1:0] pst_q [NumProd];
  logic [WCW-1:0] wfree_q [NumProd];
  logic [WAW-1:0] whead_q [NumProd];
  logic [WAW-1:0] fstart_q [NumProd];
  logic [DAW-1:0] rdp_q, wrp_q;
  logic [DCW-1:0] dfree_q;
  logic [1:0] spst_q;

  // drain cursor
  logic           own_q;
  logic [WAW-1:0] raddr_q;
  logic [WCW-1:0] len_q;
  logic [2:0]     oc_q;
  logic           drain_q;

  logic           p;
  logic           wr_ok, is_zero, desc_ok, close;
  logic [WAW-1:0] head_n;
  logic [WAW-1:0] lenm;
  logic [WCW-1:0] flen;
  logic           well_we;
  logic [MAW-1:0] well_wa, well_ra;
  logic [7:0]     well_rd;
  logic [DESCW-1:0] desc_rd;
  logic           d_own;
  logic [WAW-1:0] d_start;
  logic [WCW-1:0] d_len;
  logic [WCW:0]   nf;

  assign p       = item_i.producer;
  assign wr_ok   = cmd_i.exec && item_i.action == ACT_WRITE && pst_q[p] == P_READY
                   && wfree_q[p] != '0;
  assign is_zero = item_i.word == 8'd0;
  assign desc_ok = dfree_q != '0;
  assign close   = wr_ok && is_zero && desc_ok;
  assign head_n  = whead_q[p] + 1'b1;
  assign lenm    = head_n - fstart_q[p];
  assign flen    = (lenm == '0) ? WCW'(WellDepth) : {1'b0, lenm};
  assign well_we = wr_ok;
  assign well_wa = {p, whead_q[p]};
  assign well_ra = {own_q, raddr_q};

  soq_ram #(.Width(8), .Depth(NumProd * WellDepth)) u_well (
    .clk_i, .we_i(well_we), .waddr_i(well_wa), .wdata_i(item_i.word),
    .raddr_i(well_ra), .rdata_o(well_rd)
  );

  soq_ram #(.Width(DESCW), .Depth(1 << DAW)) u_desc (
    .clk_i, .we_i(close), .waddr_i(wrp_q), .wdata_i({p, fstart_q[p], flen}),
    .raddr_i(rdp_q), .rdata_o(desc_rd)
  );

  // descriptor read is registered, rdp_q is stable while idle
  assign d_own   = desc_rd[DESCW-1];
  assign d_start = desc_rd[DESCW-2 -: WAW];
  assign d_len   = (desc_rd[WCW-1:0] == '0 || desc_rd[WCW-1:0] > WCW'(WellDepth))
                   ? WCW'(WellDepth) : desc_rd[WCW-1:0];
  assign nf      = {1'b0, wfree_q[d_own]} + {1'b0, d_len};

  assign sts_o.drain = drain_q;
  assign sts_o.len   = len_q;
  assign files0_o = files_q[0];
  assign files1_o = files_q[1];

  always_comb begin
    res_o.has_word = drain_q;
    res_o.owner = own_q;
    res_o.out_word = drain_q ? well_rd : 8'd0;
    res_o.last = 1'b1;
    res_o.outcome = oc_q;
    res_o.state_producer0 = pst_q[0];
    res_o.state_producer1 = pst_q[1];
    res_o.state_spooler = spst_q;
    res_o.free_descriptors = 4'(dfree_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumProd; i++) begin
        files_q[i] <= 8'd1;
        left_q[i] <= 8'd1;
        pst_q[i] <= P_READY;
        wfree_q[i] <= WCW'(WellDepth);
        whead_q[i] <= '0;
        fstart_q[i] <= '0;
      end
      rdp_q <= '0;
      wrp_q <= '0;
      dfree_q <= DCW'(NumDesc);
      spst_q <= S_WAIT;
      own_q <= 1'b0;
      raddr_q <= '0;
      len_q <= '0;
      oc_q <= OC_OK;
      drain_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        files_q[cfg_idx_i] <= cfg_data_i;
        left_q[cfg_idx_i] <= cfg_data_i;
        pst_q[cfg_idx_i] <= (cfg_data_i == 8'd0) ? P_EXITED : P_READY;
      end
      if (cmd_i.rd_next) raddr_q <= raddr_q + 1'b1;
      if (cmd_i.exec) begin
        drain_q <= 1'b0;
        if (item_i.action == ACT_WRITE) begin
          own_q <= p;
          if (pst_q[p] != P_READY) begin
            oc_q <= OC_NOT_READY;
          end else if (wfree_q[p] == '0) begin
            oc_q <= OC_FULL;
            pst_q[p] <= P_WAIT_SPACE;
          end else begin
            wfree_q[p] <= wfree_q[p] - 1'b1;
            whead_q[p] <= head_n;
            oc_q <= OC_OK;
            if (is_zero && !desc_ok) begin
              oc_q <= OC_NO_DESC;
              pst_q[p] <= P_WAIT_DESC;
            end else if (is_zero) begin
              fstart_q[p] <= head_n;
              dfree_q <= dfree_q - 1'b1;
              wrp_q <= (wrp_q == DAW'(NumDesc - 1)) ? '0 : wrp_q + 1'b1;
              if (spst_q == S_WAIT) spst_q <= S_READY;
              if (left_q[p] <= 8'd1) begin
                left_q[p] <= 8'd0;
                pst_q[p] <= P_EXITED;
              end else begin
                left_q[p] <= left_q[p] - 1'b1;
              end
            end
          end
        end else begin
          own_q <= 1'b0;
          if (spst_q == S_EXITED) begin
            oc_q <= OC_SPOOL_EXIT;
          end else if (dfree_q >= DCW'(NumDesc)) begin
            if (pst_q[0] == P_EXITED && pst_q[1] == P_EXITED) begin
              spst_q <= S_EXITED;
              oc_q <= OC_SPOOL_EXIT;
            end else begin
              spst_q <= S_WAIT;
              oc_q <= OC_SPOOL_WAIT;
            end
          end else begin
            oc_q <= OC_OK;
            drain_q <= 1'b1;
            own_q <= d_own;
            raddr_q <= d_start;
            len_q <= d_len;
            wfree_q[d_own] <= (nf > (WCW+1)'(WellDepth)) ? WCW'(WellDepth)
                              : nf[WCW-1:0];
            rdp_q <= (rdp_q == DAW'(NumDesc - 1)) ? '0 : rdp_q + 1'b1;
            dfree_q <= dfree_q + 1'b1;
            if (pst_q[0] == P_WAIT_DESC) begin
              pst_q[0] <= P_READY;
              if (d_own && pst_q[1] == P_WAIT_SPACE) pst_q[1] <= P_READY;
            end else if (pst_q[1] == P_WAIT_DESC) begin
              pst_q[1] <= P_READY;
              if (!d_own && pst_q[0] == P_WAIT_SPACE) pst_q[0] <= P_READY;
            end else if (pst_q[d_own] == P_WAIT_SPACE) begin
              pst_q[d_own] <= P_READY;
            end
            spst_q <= S_READY;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/soq_ctrl.sv
// ----------------------------------------------------------------------------
// soq_ctrl
// item sequencer: execute, read, emit beats, output register
// ----------------------------------------------------------------------------
`default_nettype none
module soq_ctrl import soq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic      out_last_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      capture_o
);
  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_e;
  state_e state_q;
  logic [WCW-1:0] cnt_q;
  logic out_valid_q, last_q;
  logic take;

  // a beat enters the output register when it is empty or being taken
  assign take = state_q == ST_EMIT && (!out_valid_q || out_ready_i);
  assign in_ready_o = state_q == ST_IDLE;
  assign cmd_o.exec = in_valid_i && in_ready_o;
  assign cmd_o.rd_next = take;
  assign capture_o = take;
  assign out_valid_o = out_valid_q;
  assign out_last_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.exec) state_q <= ST_READ;
        end
        ST_READ: begin
          // count is loaded on the first read of an item only
          if (cnt_q == '0) cnt_q <= sts_i.drain ? sts_i.len : WCW'(1);
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (take) begin
            out_valid_q <= 1'b1;
            last_q <= cnt_q == WCW'(1);
            cnt_q <= cnt_q - 1'b1;
            // the next word is read from the well in ST_READ
            state_q <= (cnt_q == WCW'(1)) ? ST_IDLE : ST_READ;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/spool_output_queue_core.sv
// ----------------------------------------------------------------------------
// spool_output_queue_core
// two producer wells drained by a spooler through a descriptor ring
// ----------------------------------------------------------------------------
// flow: an item passes the read state, then the emit state, where its beat
//   enters the output register; a drain repeats both per word, as the well
//   read is registered; stalls hold emit; new items are taken only in idle
// reset: asynchronous, active low; all counters, pointers and states cleared,
//   file counts back to 1, no clearing pass
`default_nettype none
module spool_output_queue_core import soq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  soq_if.sink             in_if,
  soq_if.source           out_if,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  cmd_t cmd;
  sts_t sts;
  res_t res, res_q;
  logic capture, last, ovalid, cfg_we;
  logic [7:0] f0, f1;
  item_t item;

  assign item = in_if.data;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    case ({1'b0, paddr[2]})
      REG_FILES0: prdata = {24'd0, f0};
      REG_FILES1: prdata = {24'd0, f1};
      default: prdata = '0;
    endcase
  end

  soq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(ovalid), .out_ready_i(out_if.ready), .out_last_o(last),
    .sts_i(sts), .cmd_o(cmd), .capture_o(capture)
  );

  soq_datapath u_dp (
    .clk_i, .rst_ni, .item_i(item), .cmd_i(cmd), .sts_o(sts), .res_o(res),
    .cfg_we_i(cfg_we), .cfg_idx_i(paddr[2]), .cfg_data_i(pwdata[7:0]),
    .files0_o(f0), .files1_o(f1)
  );

  always_ff @(posedge clk_i) begin
    if (capture) res_q <= res;
  end

  assign out_if.valid = ovalid;
  always_comb begin
    out_if.data = res_q;
    out_if.data.last = last;
  end
endmodule
`default_nettype wire

// File: rtl/core/soq_checker.sv
// ----------------------------------------------------------------------------
// soq_checker
// port level checks of the spooling output queue
// ----------------------------------------------------------------------------
`default_nettype none
module soq_checker import soq_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire res_t out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");
  a_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.has_word |-> out_data.outcome == OC_OK)
    else $error("drained word with bad outcome");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.free_descriptors <= 4'(NumDesc))
    else $error("descriptor count out of range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");
endmodule

bind spool_output_queue_core soq_checker u_soq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire

// File: tb/spool_output_queue_core_chk.sv
// ----------------------------------------------------------------------------
// spool_output_queue_core_chk
// watches the item, result and register ports, predicts every result beat of
// the spooling queue and compares each beat with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module spool_output_queue_core_chk import soq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  item_t            in_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  res_t             out_data_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic        pready_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output int               pending_o,
  output int               fail_count_o
);
  logic [7:0] well_mem [NumProd*WellDepth];
  logic [6:0] well_room [NumProd];
  logic [5:0] well_wr [NumProd];
  logic [5:0] open_start [NumProd];
  logic       ring_owner [NumDesc];
  logic [5:0] ring_start [NumDesc];
  logic [6:0] ring_len [NumDesc];
  logic [2:0] ring_rd, ring_wr;
  logic [3:0] ring_room;
  logic [1:0] prod_st [NumProd];
  logic [7:0] files_todo [NumProd];
  logic [7:0] files_cfg [NumProd];
  logic [1:0] spool_st;
  res_t       beats_due [$];

  assign pending_o = beats_due.size();

  task automatic report(input string field, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    fail_count_o++;
  endtask

  task automatic add_beat(input logic has, input logic own, input logic [7:0] w,
                          input logic lst, input logic [2:0] oc);
    res_t r;
    r.has_word = has;
    r.owner = own;
    r.out_word = w;
    r.last = lst;
    r.outcome = oc;
    r.state_producer0 = prod_st[0];
    r.state_producer1 = prod_st[1];
    r.state_spooler = spool_st;
    r.free_descriptors = ring_room;
    beats_due.push_back(r);
  endtask

  task automatic reload(input int p);
    files_todo[p] = files_cfg[p];
    prod_st[p] = (files_cfg[p] == 0) ? P_EXITED : P_READY;
  endtask

  task automatic predict_write(input logic p, input logic [7:0] w);
    logic [6:0] len;
    if (prod_st[p] != P_READY) begin
      add_beat(1'b0, p, 8'd0, 1'b1, OC_NOT_READY);
    end else if (well_room[p] == 0) begin
      prod_st[p] = P_WAIT_SPACE;
      add_beat(1'b0, p, 8'd0, 1'b1, OC_FULL);
    end else begin
      well_mem[{p, well_wr[p]}] = w;
      well_room[p]--;
      well_wr[p]++;
      if (w != 0) begin
        add_beat(1'b0, p, 8'd0, 1'b1, OC_OK);
      end else if (ring_room == 0) begin
        prod_st[p] = P_WAIT_DESC;
        add_beat(1'b0, p, 8'd0, 1'b1, OC_NO_DESC);
      end else begin
        len = {1'b0, well_wr[p] - open_start[p]};
        // a file that fills the whole well
        if (len == 0) len = 7'd64;
        ring_owner[ring_wr] = p;
        ring_start[ring_wr] = open_start[p];
        ring_len[ring_wr] = len;
        open_start[p] = well_wr[p];
        ring_room--;
        ring_wr++;
        if (files_todo[p] > 0) files_todo[p]--;
        if (spool_st == S_WAIT) spool_st = S_READY;
        if (files_todo[p] == 0) prod_st[p] = P_EXITED;
        add_beat(1'b0, p, 8'd0, 1'b1, OC_OK);
      end
    end
  endtask

  task automatic predict_spool();
    logic       o;
    logic [5:0] s;
    logic [6:0] len;
    int         room;
    if (spool_st == S_EXITED) begin
      add_beat(1'b0, 1'b0, 8'd0, 1'b1, OC_SPOOL_EXIT);
    end else if (ring_room >= NumDesc) begin
      if (prod_st[0] == P_EXITED && prod_st[1] == P_EXITED) begin
        spool_st = S_EXITED;
        add_beat(1'b0, 1'b0, 8'd0, 1'b1, OC_SPOOL_EXIT);
      end else begin
        spool_st = S_WAIT;
        add_beat(1'b0, 1'b0, 8'd0, 1'b1, OC_SPOOL_WAIT);
      end
    end else begin
      o = ring_owner[ring_rd];
      s = ring_start[ring_rd];
      len = ring_len[ring_rd];
      room = well_room[o] + len;
      well_room[o] = (room > WellDepth) ? 7'd64 : room[6:0];
      if (prod_st[o] == P_WAIT_SPACE) prod_st[o] = P_READY;
      ring_rd++;
      ring_room++;
      if (prod_st[0] == P_WAIT_DESC) prod_st[0] = P_READY;
      else if (prod_st[1] == P_WAIT_DESC) prod_st[1] = P_READY;
      spool_st = S_READY;
      for (int i = 0; i < len; i++) begin
        add_beat(1'b1, o, well_mem[{o, s + i[5:0]}], (i + 1 == len), OC_OK);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumProd; p++) begin
        files_cfg[p] = 8'd1;
        well_room[p] = 7'd64;
        well_wr[p] = '0;
        open_start[p] = '0;
        reload(p);
      end
      ring_rd = '0;
      ring_wr = '0;
      ring_room = 4'(NumDesc);
      spool_st = S_WAIT;
      beats_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        // the address holds only the two file count registers
        files_cfg[paddr_i[2]] = pwdata_i[7:0];
        reload(paddr_i[2]);
      end
      if (out_valid_i && out_ready_i) begin
        if (beats_due.size() == 0) begin
          report("unexpected beat", 1, 0);
        end else begin
          res_t e;
          e = beats_due.pop_front();
          if (out_data_i.has_word !== e.has_word)
            report("has_word", out_data_i.has_word, e.has_word);
          if (out_data_i.owner !== e.owner) report("owner", out_data_i.owner, e.owner);
          if (out_data_i.out_word !== e.out_word)
            report("out_word", out_data_i.out_word, e.out_word);
          if (out_data_i.last !== e.last) report("last", out_data_i.last, e.last);
          if (out_data_i.outcome !== e.outcome)
            report("outcome", out_data_i.outcome, e.outcome);
          if (out_data_i.state_producer0 !== e.state_producer0)
            report("state_producer0", out_data_i.state_producer0, e.state_producer0);
          if (out_data_i.state_producer1 !== e.state_producer1)
            report("state_producer1", out_data_i.state_producer1, e.state_producer1);
          if (out_data_i.state_spooler !== e.state_spooler)
            report("state_spooler", out_data_i.state_spooler, e.state_spooler);
          if (out_data_i.free_descriptors !== e.free_descriptors)
            report("free_descriptors", out_data_i.free_descriptors, e.free_descriptors);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.action == ACT_SPOOL) predict_spool();
        else predict_write(in_data_i.producer, in_data_i.word);
      end
    end
  end

  initial fail_count_o = 0;
endmodule

// File: tb/spool_output_queue_core_tb.sv
// ----------------------------------------------------------------------------
// spool_output_queue_core_tb
// drives write and spool items with random gaps and stalls through several
// file count settings, including full wells, a full descriptor ring and the
// spooler exit; a separate checker predicts and compares every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module spool_output_queue_core_tb;
  import soq_pkg::*;

  localparam int WatchLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        calm = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          pending;
  int          fail_count;

  soq_if #(.T(item_t)) in_ch ();
  soq_if #(.T(res_t))  out_ch ();

  spool_output_queue_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  spool_output_queue_core_chk chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
  end

  // result side: stall after a beat for a drawn number of cycles
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      int n;
      n = calm ? 0 : $urandom_range(0, 11);
      if (n != 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= n;
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(input logic act, input logic p, input logic [7:0] w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{action: act, producer: p, word: w};
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic settle();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    // let the checker log the last accepted item first
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_files(input logic [1:0] idx, input logic [7:0] n);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx[0], 2'b00};
    pwdata <= {24'd0, n};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 15);
    if (r < 4) send(ACT_SPOOL, 1'($urandom), 8'($urandom));
    else if (r < 6) send(ACT_WRITE, 1'($urandom), 8'd0);
    else send(ACT_WRITE, 1'($urandom), 8'($urandom_range(1, 255)));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, short file, producer done, not ready
    send(ACT_SPOOL, 1'b0, 8'd0);
    send(ACT_WRITE, 1'b0, 8'd255);
    send(ACT_WRITE, 1'b0, 8'd1);
    send(ACT_WRITE, 1'b0, 8'd0);
    send(ACT_WRITE, 1'b0, 8'd7);
    send(ACT_SPOOL, 1'b1, 8'd255);
    settle();

    write_files(REG_FILES0, 8'd255);
    write_files(REG_FILES1, 8'd255);
    // a file filling the whole well, then a full well
    for (int i = 0; i < 63; i++) send(ACT_WRITE, 1'b1, 8'($urandom_range(1, 255)));
    send(ACT_WRITE, 1'b1, 8'd0);
    send(ACT_WRITE, 1'b1, 8'd128);
    send(ACT_WRITE, 1'b1, 8'd128);
    // ring runs out of descriptors
    for (int i = 0; i < 8; i++) send(ACT_WRITE, 1'b0, 8'd0);
    send(ACT_WRITE, 1'b0, 8'd3);
    for (int i = 0; i < 10; i++) send(ACT_SPOOL, 1'b0, 8'd0);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      calm = (ph == 2);
      case (ph)
        0: begin
          write_files(REG_FILES0, 8'd255);
          write_files(REG_FILES1, 8'd0);
        end
        1: begin
          write_files(REG_FILES0, 8'd3);
          write_files(REG_FILES1, 8'd5);
        end
        default: begin
          write_files(REG_FILES0, 8'($urandom_range(1, 255)));
          write_files(REG_FILES1, 8'($urandom_range(1, 255)));
        end
      endcase
      for (int i = 0; i < 50; i++) random_item();
      settle();
    end
    calm = 1'b0;

    // everyone exits, then the spooler drains out and exits too
    write_files(REG_FILES0, 8'd0);
    write_files(REG_FILES1, 8'd0);
    for (int i = 0; i < 12; i++) send(ACT_SPOOL, 1'b0, 8'd0);
    send(ACT_WRITE, 1'b1, 8'd9);
    settle();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/soq_pkg.sv
rtl/core/soq_if.sv
rtl/core/soq_ram.sv
rtl/core/soq_datapath.sv
rtl/core/soq_ctrl.sv
rtl/core/spool_output_queue_core.sv
rtl/core/soq_checker.sv
tb/spool_output_queue_core_chk.sv
tb/spool_output_queue_core_tb.sv
